// ----- sv/olca_pkg.sv -----
package olca_pkg;

    localparam int NODES      = 65536;
    localparam int LEVELS     = 17;
    localparam int NODE_W     = $clog2(NODES);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int DEP_W      = 16;
    localparam int DIST_IDX_W = $clog2(DEP_W);
    localparam int FIELD_W    = 16;

    // request codes
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DRD,
        S_DCAP,
        S_ADD_RD,
        S_ADD_WR,
        S_LIFT,
        S_LIFT_CAP,
        S_JRD,
        S_JCAP,
        S_FIN,
        S_FCAP
    } t_state;

    typedef struct packed {
        logic              clr;
        logic [NODE_W-1:0] clr_addr;
        logic              load;
        logic              add_dwr;
        logic              add_wr;
        logic              q_dcap;
        logic              lift;
        logic              lift_cap;
        logic              joint_cap;
        logic              fin_self;
        logic              fin_cap;
        logic [LVL_W-1:0]  lvl;
    } t_cmd;

    typedef struct packed {
        logic dist_bit;
        logic same_xy;
        logic out_full;
    } t_stat;

endpackage

// ----- sv/online_lca_binary_lifting_top.sv -----
// online lowest common ancestor, binary lifting over a growing rooted tree
//
// input channel (i_valid / o_ready): one beat is a request. i_req_type low
// hangs node i_node_b under parent i_node_a; high asks for the lowest common
// ancestor of i_node_a and i_node_b. node 0 is the root.
// output channel (o_valid / i_ready): one beat per query on o_ancestor; an
// add gives no beat.
// timing: one request at a time, paced by the single read port pair of the
// jump memories, each read registered and the next address depending on it.
// an add reads the depths, then a read and a write step per jump level. a
// query reads the depths, tests each bit of the 16-bit depth difference and
// captures a lift on each set bit, reads and captures each level for the
// joint lift, and finishes with a capture when the nodes still differ.
// reset: a clearing pass over all 65536 nodes zeroes the depth memory and all
// jump levels, one node per cycle; o_ready stays low until it is done.
// stall: the result sits in an output register; new requests are taken
// while it waits, and a following query stalls only at its last step until
// the receiver takes the previous beat.
module online_lca_binary_lifting_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_req_type,
    input  logic [olca_pkg::FIELD_W-1:0] i_node_a,
    input  logic [olca_pkg::FIELD_W-1:0] i_node_b,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [olca_pkg::FIELD_W-1:0] o_ancestor
);

    // controller to datapath commands and status back
    olca_pkg::t_cmd  cmd;
    olca_pkg::t_stat stat;

    // sequencer: clearing pass, add walk, lift and joint lift
    olca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // depth memory, one memory per jump level, node registers, result register
    olca_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_ancestor  (o_ancestor)
    );

endmodule

// ----- sv/olca_ram.sv -----
module olca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ----- sv/olca_dpath.sv -----
module olca_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  olca_pkg::t_cmd                      i_cmd,
    output olca_pkg::t_stat                     o_stat,
    input  logic [olca_pkg::FIELD_W-1:0]        i_node_a,
    input  logic [olca_pkg::FIELD_W-1:0]        i_node_b,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [olca_pkg::FIELD_W-1:0]        o_ancestor
);

    logic [olca_pkg::NODE_W-1:0] r_x;
    logic [olca_pkg::NODE_W-1:0] r_y;
    logic [olca_pkg::DEP_W-1:0]  r_dist;
    logic                        r_lift_b;
    logic [olca_pkg::NODE_W-1:0] r_res;
    logic                        r_out_valid;

    logic [olca_pkg::NODE_W-1:0] raddr0;
    logic [olca_pkg::NODE_W-1:0] waddr;
    logic [olca_pkg::NODE_W-1:0] jmp_rd0 [olca_pkg::LEVELS];
    logic [olca_pkg::NODE_W-1:0] jmp_rd1 [olca_pkg::LEVELS];
    logic [olca_pkg::NODE_W-1:0] sel0;
    logic [olca_pkg::NODE_W-1:0] sel1;
    logic [olca_pkg::NODE_W-1:0] jmp_wdata;
    logic [olca_pkg::LVL_W-1:0]  wlvl;
    logic [olca_pkg::DEP_W-1:0]  dep_rd0;
    logic [olca_pkg::DEP_W-1:0]  dep_rd1;
    logic [olca_pkg::DEP_W-1:0]  dep_wdata;
    logic                        dep_we;

    // port 0 follows the node being lifted, port 1 always the second node
    assign raddr0    = (i_cmd.lift && r_lift_b) ? r_y : r_x;
    assign waddr     = i_cmd.clr ? i_cmd.clr_addr : r_y;
    assign sel0      = jmp_rd0[i_cmd.lvl];
    assign sel1      = jmp_rd1[i_cmd.lvl];
    assign wlvl      = i_cmd.lvl + olca_pkg::LVL_W'(1);
    assign jmp_wdata = i_cmd.clr ? '0 : (i_cmd.add_dwr ? r_x : sel0);

    // child depth saturates at the top
    assign dep_we    = i_cmd.clr || i_cmd.add_dwr;
    assign dep_wdata = i_cmd.clr ? '0 :
                       ((dep_rd0 == '1) ? dep_rd0 : dep_rd0 + olca_pkg::DEP_W'(1));

    olca_ram #(
        .WIDTH (olca_pkg::DEP_W),
        .DEPTH (olca_pkg::NODES)
    ) u_depth (
        .i_clk    (i_clk),
        .i_we     (dep_we),
        .i_waddr  (waddr),
        .i_wdata  (dep_wdata),
        .i_raddr0 (r_x),
        .i_raddr1 (r_y),
        .o_rdata0 (dep_rd0),
        .o_rdata1 (dep_rd1)
    );

    for (genvar g = 0; g < olca_pkg::LEVELS; g++) begin : g_jump
        logic we;
        assign we = i_cmd.clr || (i_cmd.add_dwr && (g == 0)) ||
                    (i_cmd.add_wr && (wlvl == olca_pkg::LVL_W'(g)));
        olca_ram #(
            .WIDTH (olca_pkg::NODE_W),
            .DEPTH (olca_pkg::NODES)
        ) u_jump (
            .i_clk    (i_clk),
            .i_we     (we),
            .i_waddr  (waddr),
            .i_wdata  (jmp_wdata),
            .i_raddr0 (raddr0),
            .i_raddr1 (r_y),
            .o_rdata0 (jmp_rd0[g]),
            .o_rdata1 (jmp_rd1[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_node_a[olca_pkg::NODE_W-1:0];
            r_y <= i_node_b[olca_pkg::NODE_W-1:0];
        end
        if (i_cmd.q_dcap) begin
            if (dep_rd1 > dep_rd0) begin
                r_lift_b <= 1'b1;
                r_dist   <= dep_rd1 - dep_rd0;
            end else begin
                r_lift_b <= 1'b0;
                r_dist   <= dep_rd0 - dep_rd1;
            end
        end
        if (i_cmd.add_wr) begin
            r_x <= sel0;
        end
        if (i_cmd.lift_cap) begin
            if (r_lift_b) begin
                r_y <= sel0;
            end else begin
                r_x <= sel0;
            end
        end
        if (i_cmd.joint_cap && (sel0 != sel1)) begin
            r_x <= sel0;
            r_y <= sel1;
        end
        if (i_cmd.fin_self) begin
            r_res <= r_x;
        end
        if (i_cmd.fin_cap) begin
            r_res <= sel0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_self || i_cmd.fin_cap) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.dist_bit = r_dist[i_cmd.lvl[olca_pkg::DIST_IDX_W-1:0]];
    assign o_stat.same_xy  = (r_x == r_y);
    assign o_stat.out_full = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_ancestor  = olca_pkg::FIELD_W'(r_res);

endmodule

// ----- sv/olca_ctrl.sv -----
module olca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_req_type,
    output olca_pkg::t_cmd  o_cmd,
    input  olca_pkg::t_stat i_stat
);

    olca_pkg::t_state            r_state;
    olca_pkg::t_state            n_state;
    logic [olca_pkg::LVL_W-1:0]  r_lvl;
    logic [olca_pkg::LVL_W-1:0]  n_lvl;
    logic [olca_pkg::NODE_W-1:0] r_cnt;
    logic [olca_pkg::NODE_W-1:0] n_cnt;
    logic                        r_is_query;
    logic                        n_is_query;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olca_pkg::S_CLEAR: begin
                if (r_cnt == olca_pkg::NODE_W'(olca_pkg::NODES - 1)) begin
                    n_state = olca_pkg::S_IDLE;
                end
            end
            olca_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = olca_pkg::S_DRD;
                end
            end
            olca_pkg::S_DRD: n_state = olca_pkg::S_DCAP;
            olca_pkg::S_DCAP: begin
                n_state = r_is_query ? olca_pkg::S_LIFT : olca_pkg::S_ADD_RD;
            end
            olca_pkg::S_ADD_RD: n_state = olca_pkg::S_ADD_WR;
            olca_pkg::S_ADD_WR: begin
                if (r_lvl == olca_pkg::LVL_W'(olca_pkg::LEVELS - 2)) begin
                    n_state = olca_pkg::S_IDLE;
                end else begin
                    n_state = olca_pkg::S_ADD_RD;
                end
            end
            olca_pkg::S_LIFT: begin
                priority if (i_stat.dist_bit) begin
                    n_state = olca_pkg::S_LIFT_CAP;
                end else if (r_lvl == '0) begin
                    n_state = olca_pkg::S_JRD;
                end else begin
                    n_state = olca_pkg::S_LIFT;
                end
            end
            olca_pkg::S_LIFT_CAP: begin
                n_state = (r_lvl == '0) ? olca_pkg::S_JRD : olca_pkg::S_LIFT;
            end
            olca_pkg::S_JRD: n_state = olca_pkg::S_JCAP;
            olca_pkg::S_JCAP: begin
                n_state = (r_lvl == '0) ? olca_pkg::S_FIN : olca_pkg::S_JRD;
            end
            olca_pkg::S_FIN: begin
                priority if (!i_stat.same_xy) begin
                    n_state = olca_pkg::S_FCAP;
                end else if (!i_stat.out_full) begin
                    n_state = olca_pkg::S_IDLE;
                end else begin
                    n_state = olca_pkg::S_FIN;
                end
            end
            olca_pkg::S_FCAP: begin
                if (!i_stat.out_full) begin
                    n_state = olca_pkg::S_IDLE;
                end
            end
            default: n_state = olca_pkg::S_IDLE;
        endcase
    end

    // commands and counters
    always_comb begin
        o_cmd          = '0;
        o_cmd.lvl      = r_lvl;
        o_cmd.clr_addr = r_cnt;
        o_ready        = 1'b0;
        n_lvl          = r_lvl;
        n_cnt          = r_cnt;
        n_is_query     = r_is_query;
        unique case (r_state)
            olca_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_cnt     = r_cnt + olca_pkg::NODE_W'(1);
            end
            olca_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_is_query = (i_req_type == olca_pkg::REQ_QUERY);
                end
            end
            olca_pkg::S_DRD: begin
            end
            olca_pkg::S_DCAP: begin
                if (r_is_query) begin
                    o_cmd.q_dcap = 1'b1;
                    n_lvl        = olca_pkg::LVL_W'(olca_pkg::DEP_W - 1);
                end else begin
                    o_cmd.add_dwr = 1'b1;
                    n_lvl         = '0;
                end
            end
            olca_pkg::S_ADD_RD: begin
            end
            olca_pkg::S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_lvl        = r_lvl + olca_pkg::LVL_W'(1);
            end
            olca_pkg::S_LIFT: begin
                o_cmd.lift = 1'b1;
                priority if (i_stat.dist_bit) begin
                    n_lvl = r_lvl;
                end else if (r_lvl == '0) begin
                    n_lvl = olca_pkg::LVL_W'(olca_pkg::LEVELS - 1);
                end else begin
                    n_lvl = r_lvl - olca_pkg::LVL_W'(1);
                end
            end
            olca_pkg::S_LIFT_CAP: begin
                o_cmd.lift_cap = 1'b1;
                if (r_lvl == '0) begin
                    n_lvl = olca_pkg::LVL_W'(olca_pkg::LEVELS - 1);
                end else begin
                    n_lvl = r_lvl - olca_pkg::LVL_W'(1);
                end
            end
            olca_pkg::S_JRD: begin
            end
            olca_pkg::S_JCAP: begin
                o_cmd.joint_cap = 1'b1;
                if (r_lvl != '0) begin
                    n_lvl = r_lvl - olca_pkg::LVL_W'(1);
                end
            end
            olca_pkg::S_FIN: begin
                o_cmd.fin_self = i_stat.same_xy && !i_stat.out_full;
            end
            olca_pkg::S_FCAP: begin
                o_cmd.fin_cap = !i_stat.out_full;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= olca_pkg::S_CLEAR;
            r_lvl      <= '0;
            r_cnt      <= '0;
            r_is_query <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_lvl      <= n_lvl;
            r_cnt      <= n_cnt;
            r_is_query <= n_is_query;
        end
    end

    // a result is never loaded over one that the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fin_self || o_cmd.fin_cap) |-> !i_stat.out_full)
        else $error("result loaded while output register is held");

    // level counter never leaves the jump table
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= olca_pkg::LVL_W'(olca_pkg::LEVELS - 1))
        else $error("level counter out of range");

    // the clearing pass starts right after reset and takes no beats
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_state == olca_pkg::S_CLEAR) && (r_cnt == '0))
        else $error("clearing pass did not start after reset");

    a_clear_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr |-> !o_ready && !o_cmd.load)
        else $error("input taken during clearing pass");

    // add writes only target levels above the parent level
    a_add_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add_wr |-> !r_is_query &&
            (r_lvl <= olca_pkg::LVL_W'(olca_pkg::LEVELS - 2)))
        else $error("jump write at bad level");

endmodule
